// ----- src/vtpa_pkg.sv -----
// Package for the vertex track pair angle core.
// Holds widths, config register index codes and the arctangent table; no dependencies.
package vtpa_pkg;
    localparam int CoordW = 20;
    localparam int DirW   = 48;
    localparam int LenW   = 24;
    localparam int AngW   = 16;
    localparam int DistW  = 16;
    localparam int AngleIterations = 16;
    localparam int IterW  = 5;

    localparam logic [1:0] CfgVx = 2'd0;
    localparam logic [1:0] CfgVy = 2'd1;
    localparam logic [1:0] CfgVz = 2'd2;
    localparam logic [1:0] CfgMd = 2'd3;

    localparam logic [31:0] HalfPiQ14 = 32'd25736;
    localparam logic [15:0] PiQ14     = 16'd51472;

    function automatic logic [13:0] atan_q14(input logic [IterW-1:0] i);
        case (i)
            5'd0:  atan_q14 = 14'd12868;
            5'd1:  atan_q14 = 14'd7596;
            5'd2:  atan_q14 = 14'd4014;
            5'd3:  atan_q14 = 14'd2037;
            5'd4:  atan_q14 = 14'd1023;
            5'd5:  atan_q14 = 14'd512;
            5'd6:  atan_q14 = 14'd256;
            5'd7:  atan_q14 = 14'd128;
            5'd8:  atan_q14 = 14'd64;
            5'd9:  atan_q14 = 14'd32;
            5'd10: atan_q14 = 14'd16;
            5'd11: atan_q14 = 14'd8;
            5'd12: atan_q14 = 14'd4;
            5'd13: atan_q14 = 14'd2;
            5'd14: atan_q14 = 14'd1;
            default: atan_q14 = 14'd0;
        endcase
    endfunction

    function automatic logic signed [15:0] dcomp(input logic [DirW-1:0] d, input logic [1:0] k);
        case (k)
            2'd0: dcomp = d[47:32];
            2'd1: dcomp = d[31:16];
            default: dcomp = d[15:0];
        endcase
    endfunction
endpackage

// ----- src/vertex_track_pair_angle_core.sv -----
// Top level: track selection, top-two tracking and result stage.
// Depends on vtpa_pkg and vtpa_angle.

// A request tests its start against the distance limit and its end only when
// the start fails: three products per point on one shared squarer, the
// top-two update, then the SUpd state. o_stall stays high meanwhile. On the
// last track with a pair, the angle unit runs 9 products, 3 squares, 32 root
// steps, 16 CORDIC steps, a finish step and the output load, and skips the
// CORDIC steps when cross and dot both truncate to zero. A last track without
// a pair goes straight to the output stage. The result sits in an output
// register; the next request is taken as soon as it is loaded, and at the
// output stage a last track waits only while it still holds an unread result.
module vertex_track_pair_angle_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_index,
    input  logic [vtpa_pkg::CoordW-1:0]           i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [vtpa_pkg::CoordW-1:0]    i_start_x,
    input  logic signed [vtpa_pkg::CoordW-1:0]    i_start_y,
    input  logic signed [vtpa_pkg::CoordW-1:0]    i_start_z,
    input  logic signed [vtpa_pkg::CoordW-1:0]    i_end_x,
    input  logic signed [vtpa_pkg::CoordW-1:0]    i_end_y,
    input  logic signed [vtpa_pkg::CoordW-1:0]    i_end_z,
    input  logic [vtpa_pkg::DirW-1:0]             i_start_direction,
    input  logic [vtpa_pkg::DirW-1:0]             i_end_direction,
    input  logic [vtpa_pkg::LenW-1:0]             i_track_length,
    input  logic                                  i_last_track,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [vtpa_pkg::AngW-1:0]             o_angle,
    output logic                                  o_no_pair
);
    import vtpa_pkg::*;

    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SDist = 3'd1;
    localparam logic [2:0] SUpd  = 3'd2;
    localparam logic [2:0] SAng  = 3'd3;
    localparam logic [2:0] SOut  = 3'd4;

    logic signed [CoordW-1:0] r_vx, r_vy, r_vz;
    logic [DistW-1:0] r_md;
    logic [2:0] r_st;
    logic [2:0] r_cnt;
    logic [CoordW-1:0] r_sx, r_sy, r_sz, r_ex, r_ey, r_ez;
    logic [DirW-1:0] r_sd, r_ed;
    logic [LenW-1:0] r_len;
    logic r_last;
    logic [42:0] r_acc;
    logic [LenW-1:0] r_bl, r_sl;
    logic [DirW-1:0] r_bd, r_sd2;
    logic [1:0] r_kc;
    logic r_ov;
    logic [AngW-1:0] r_ang;
    logic r_np;
    logic ang_start, ang_done;
    logic [AngW-1:0] ang_val;
    logic signed [CoordW:0] diff;
    logic [41:0] dsq;
    logic [42:0] acc_n;
    logic [31:0] lim;
    logic near_n;
    logic keep;
    logic [DirW-1:0] dir, rev;
    logic signed [16:0] nc;

    always_comb begin
        case (r_cnt)
            3'd0: diff = (CoordW+1)'($signed(r_sx)) - (CoordW+1)'(r_vx);
            3'd1: diff = (CoordW+1)'($signed(r_sy)) - (CoordW+1)'(r_vy);
            3'd2: diff = (CoordW+1)'($signed(r_sz)) - (CoordW+1)'(r_vz);
            3'd3: diff = (CoordW+1)'($signed(r_ex)) - (CoordW+1)'(r_vx);
            3'd4: diff = (CoordW+1)'($signed(r_ey)) - (CoordW+1)'(r_vy);
            default: diff = (CoordW+1)'($signed(r_ez)) - (CoordW+1)'(r_vz);
        endcase
        dsq = 42'(diff * diff);
        acc_n = ((r_cnt == 3'd0 || r_cnt == 3'd3) ? 43'd0 : r_acc) + 43'(dsq);
        lim = r_md * r_md;
        near_n = acc_n < 43'(lim);
        for (int k = 0; k < 3; k++) begin
            nc = -17'(dcomp(r_ed, 2'(k)));
            if (nc > 17'sd32767) nc = 17'sd32767;
            rev[47-16*k -: 16] = nc[15:0];
        end
        keep = near_n;
        dir = (r_cnt == 3'd2) ? r_sd : rev;
    end

    assign ang_start = (r_st == SUpd) && r_last && r_kc == 2'd2;

    vtpa_angle u_angle (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(ang_start),
        .i_dir_a(r_bd),
        .i_dir_b(r_sd2),
        .o_done (ang_done),
        .o_angle(ang_val)
    );

    assign o_stall   = (r_st != SIdle);
    assign o_valid   = r_ov;
    assign o_angle   = r_ang;
    assign o_no_pair = r_np;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0; r_vy <= '0; r_vz <= '0; r_md <= 16'd640;
            r_st <= SIdle; r_cnt <= '0; r_kc <= '0; r_ov <= 1'b0;
            r_bl <= '0; r_sl <= '0; r_bd <= '0; r_sd2 <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CfgVx: r_vx <= i_cfg_data;
                    CfgVy: r_vy <= i_cfg_data;
                    CfgVz: r_vz <= i_cfg_data;
                    CfgMd: r_md <= i_cfg_data[DistW-1:0];
                    default: ;
                endcase
            end
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_st)
                SIdle: if (i_valid && !o_stall) begin
                    r_sx <= i_start_x; r_sy <= i_start_y; r_sz <= i_start_z;
                    r_ex <= i_end_x; r_ey <= i_end_y; r_ez <= i_end_z;
                    r_sd <= i_start_direction; r_ed <= i_end_direction;
                    r_len <= i_track_length; r_last <= i_last_track;
                    r_cnt <= '0; r_st <= SDist;
                end
                SDist: begin
                    r_acc <= acc_n;
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd5 || (r_cnt == 3'd2 && near_n)) begin
                        r_st <= SUpd;
                        if (keep) begin
                            if (r_kc >= 2'd1 && r_len > r_bl) begin
                                r_sl <= r_bl; r_sd2 <= r_bd;
                                r_bl <= r_len; r_bd <= dir;
                            end else if (r_kc == 2'd0) begin
                                r_bl <= r_len; r_bd <= dir;
                            end else if (r_kc == 2'd1 || r_len > r_sl) begin
                                r_sl <= r_len; r_sd2 <= dir;
                            end
                            if (r_kc < 2'd2) r_kc <= r_kc + 2'd1;
                        end
                    end
                end
                SUpd: begin
                    if (!r_last) r_st <= SIdle;
                    else if (r_kc == 2'd2) r_st <= SAng;
                    else r_st <= SOut;
                end
                SAng: if (ang_done) begin
                    r_st <= SOut;
                end
                SOut: if (!r_ov) begin
                    r_ov <= 1'b1;
                    r_ang <= (r_kc == 2'd2) ? ang_val : '0;
                    r_np <= (r_kc != 2'd2);
                    r_kc <= '0; r_bl <= '0; r_sl <= '0; r_bd <= '0; r_sd2 <= '0;
                    r_st <= SIdle;
                end
                default: r_st <= SIdle;
            endcase
        end
    end
endmodule

// ----- src/vtpa_angle.sv -----
// Angle unit: shared multiplier for cross/dot, bit-serial square root, CORDIC.
// Depends on vtpa_pkg.
module vtpa_angle (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vtpa_pkg::DirW-1:0]  i_dir_a,
    input  logic [vtpa_pkg::DirW-1:0]  i_dir_b,
    output logic                       o_done,
    output logic [vtpa_pkg::AngW-1:0]  o_angle
);
    import vtpa_pkg::*;

    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SMul  = 3'd1;
    localparam logic [2:0] SSq   = 3'd2;
    localparam logic [2:0] SSqrt = 3'd3;
    localparam logic [2:0] SCord = 3'd4;
    localparam logic [2:0] SFin  = 3'd5;

    logic [2:0] r_st, n_st;
    logic [3:0] r_cnt, n_cnt;
    logic [IterW-1:0] r_it, n_it;
    logic signed [33:0] r_cx, r_cy, r_cz, r_dot, n_cx, n_cy, n_cz, n_dot;
    logic [63:0] r_sum, n_sum;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic signed [40:0] r_x, r_y, n_x, n_y;
    logic signed [31:0] r_z, n_z;
    logic [AngW-1:0] r_ang, n_ang;
    logic [DirW-1:0] r_a, r_b, n_a, n_b;

    logic signed [15:0] m_a, m_b;
    logic signed [31:0] prod;
    logic [31:0] sq_in;
    logic [63:0] sq;
    logic [31:0] cxm, cym, czm, dm;
    logic [33:0] trial;
    logic [63:0] rem_sh;
    logic signed [31:0] zc;

    function automatic logic [31:0] mt(input logic signed [33:0] v);
        logic [33:0] m;
        m = v[33] ? 34'(-v) : 34'(v);
        mt = m[33:2];
    endfunction

    always_comb begin
        cxm = mt(r_cx); cym = mt(r_cy); czm = mt(r_cz); dm = mt(r_dot);
        m_a = '0; m_b = '0;
        case (r_cnt)
            4'd0: begin m_a = dcomp(r_a, 2'd1); m_b = dcomp(r_b, 2'd2); end
            4'd1: begin m_a = dcomp(r_a, 2'd2); m_b = dcomp(r_b, 2'd1); end
            4'd2: begin m_a = dcomp(r_a, 2'd2); m_b = dcomp(r_b, 2'd0); end
            4'd3: begin m_a = dcomp(r_a, 2'd0); m_b = dcomp(r_b, 2'd2); end
            4'd4: begin m_a = dcomp(r_a, 2'd0); m_b = dcomp(r_b, 2'd1); end
            4'd5: begin m_a = dcomp(r_a, 2'd1); m_b = dcomp(r_b, 2'd0); end
            4'd6: begin m_a = dcomp(r_a, 2'd0); m_b = dcomp(r_b, 2'd0); end
            4'd7: begin m_a = dcomp(r_a, 2'd1); m_b = dcomp(r_b, 2'd1); end
            default: begin m_a = dcomp(r_a, 2'd2); m_b = dcomp(r_b, 2'd2); end
        endcase
        prod = m_a * m_b;
        case (r_cnt)
            4'd0: sq_in = cxm;
            4'd1: sq_in = cym;
            default: sq_in = czm;
        endcase
        sq = sq_in * sq_in;
        rem_sh = {r_rem[61:0], r_sum[63:62]};
        trial = {r_root, 2'b01};
        zc = r_z;
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_it = r_it;
        n_cx = r_cx; n_cy = r_cy; n_cz = r_cz; n_dot = r_dot;
        n_sum = r_sum; n_rem = r_rem; n_root = r_root;
        n_x = r_x; n_y = r_y; n_z = r_z; n_ang = r_ang;
        n_a = r_a; n_b = r_b;
        o_done = 1'b0;
        case (r_st)
            SIdle: if (i_start) begin
                n_a = i_dir_a; n_b = i_dir_b; n_cnt = '0;
                n_cx = '0; n_cy = '0; n_cz = '0; n_dot = '0;
                n_st = SMul;
            end
            SMul: begin
                case (r_cnt)
                    4'd0: n_cx = 34'(prod);
                    4'd1: n_cx = r_cx - 34'(prod);
                    4'd2: n_cy = 34'(prod);
                    4'd3: n_cy = r_cy - 34'(prod);
                    4'd4: n_cz = 34'(prod);
                    4'd5: n_cz = r_cz - 34'(prod);
                    default: n_dot = r_dot + 34'(prod);
                endcase
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd8) begin
                    n_cnt = '0; n_sum = '0; n_st = SSq;
                end
            end
            SSq: begin
                n_sum = r_sum + sq;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) begin
                    n_cnt = '0; n_rem = '0; n_root = '0; n_it = '0; n_st = SSqrt;
                end
            end
            SSqrt: begin
                n_sum = {r_sum[61:0], 2'b00};
                if (rem_sh >= 64'(trial)) begin
                    n_rem = rem_sh - 64'(trial);
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_root = {r_root[30:0], 1'b0};
                end
                n_it = r_it + 5'd1;
                if (r_it == 5'd31) begin
                    n_it = '0;
                    n_x = 41'(dm); n_y = 41'(n_root); n_z = '0;
                    if (dm == '0 && n_root == '0) begin
                        n_ang = '0; n_st = SFin;
                    end else begin
                        n_st = SCord;
                    end
                end
            end
            SCord: begin
                if (r_y > 0) begin
                    n_x = r_x + (r_y >>> r_it);
                    n_y = r_y - (r_x >>> r_it);
                    n_z = r_z + 32'(atan_q14(r_it));
                end else begin
                    n_x = r_x - (r_y >>> r_it);
                    n_y = r_y + (r_x >>> r_it);
                    n_z = r_z - 32'(atan_q14(r_it));
                end
                n_it = r_it + 5'd1;
                if (r_it == 5'(AngleIterations - 1)) begin
                    n_st = SFin; n_cnt = 4'd1;
                end
            end
            SFin: begin
                if (r_cnt == 4'd1) begin
                    if (zc < 0) n_ang = '0;
                    else if (zc > $signed(HalfPiQ14)) n_ang = HalfPiQ14[15:0];
                    else n_ang = zc[15:0];
                    if (r_dot < 0) n_ang = PiQ14 - n_ang;
                end
                o_done = 1'b1;
                n_cnt = '0;
                n_st = SIdle;
            end
            default: n_st = SIdle;
        endcase
    end

    assign o_angle = (r_st == SFin && r_cnt == 4'd1) ? n_ang : r_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SIdle; r_cnt <= '0; r_it <= '0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_it <= n_it;
        end
        r_cx <= n_cx; r_cy <= n_cy; r_cz <= n_cz; r_dot <= n_dot;
        r_sum <= n_sum; r_rem <= n_rem; r_root <= n_root;
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_ang <= n_ang;
        r_a <= n_a; r_b <= n_b;
    end
endmodule
